### src/tcs_pkg.sv
// Shared constants and types of the temporal crop smoother.
package tcs_pkg;

   localparam int COORD_LIMIT = 32768;
   localparam int FRAC_BITS   = 8;
   localparam int WEIGHT_BITS = 16;
   localparam int REG_MAX     = 65536;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_HISTORY_CAP  = 2'd0,
      CSR_MOTION_SHARE = 2'd1,
      CSR_FRAME_COLS   = 2'd2,
      CSR_FRAME_ROWS   = 2'd3
   } csr_index_type;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_CHK   = 11'b000_0000_0010,
      ST_WPRE  = 11'b000_0000_0100,
      ST_WCMP  = 11'b000_0000_1000,
      ST_WDIV  = 11'b000_0001_0000,
      ST_WSEL  = 11'b000_0010_0000,
      ST_BLEND = 11'b000_0100_0000,
      ST_VMUL  = 11'b000_1000_0000,
      ST_VDIV  = 11'b001_0000_0000,
      ST_CROP  = 11'b010_0000_0000,
      ST_FIN   = 11'b100_0000_0000
   } state_type;

endpackage

### src/temporal_crop_smoother.sv
// Top level of the temporal crop smoother.
//
// One detected box per video frame enters on the req_ stream; one result per
// box leaves on the rsp_ stream. The csr_ port writes the four registers
// (history cap, motion share, frame columns, frame rows); the user must do
// so only while idle, the block does not enforce it. A box outside limits
// is answered with rsp_tuser = 0 and the last crop. The first valid box
// passes through; later boxes blend with the smoothed centre and extent by a
// history weight and are clamped to the frame.
// A rejected or first box goes from the check straight to the final state.
// Any other box runs check and weight setup, the bit-serial weight division,
// weight select, the shared blend multiplier, the load of the vertical
// extent product, its bit-serial division, the crop build, and the clamp
// and output load. When the motion budget covers the move the weight
// division is skipped. One box is worked on at a time; req_tready is high
// only while idle, so a new box is taken only after the last result has
// gone to the output register.
// The result sits in an output register; a stalled receiver holds the block
// in its final state until that register is free, nothing is dropped.
// Reset (synchronous) restores the register defaults, clears the
// smoothed state and counter and marks the next box as the first one.
module temporal_crop_smoother
   import tcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // box_left[16:0], box_top[33:17], box_wide[49:34], box_tall[65:50], zero pad
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // crop_left[17:0], crop_top[35:18], crop_wide[53:36], crop_tall[71:54],
   // frames_done[103:72]
   output logic [103:0] rsp_tdata,
   // accepted[0]
   output logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [16:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [16:0] cap_ff, share_ff;
   logic [15:0] cols_ff, rows_ff;

   logic signed [16:0] bx_ff, by_ff;
   logic [15:0]        bw_ff, bh_ff;

   logic               first_ff;
   logic signed [25:0] scx_ff, scy_ff;
   logic [23:0]        sext_ff;
   logic [31:0]        count_ff;
   logic [17:0]        crop_ff [0:3];
   logic               acc_ff;

   logic [32:0]  msprod_ff;
   logic [26:0]  dist_ff;
   logic [43:0]  wrem_ff;
   logic [16:0]  uw_ff, wt_ff;
   logic [5:0]   cnt_ff;

   logic signed [43:0] prod_ff;
   logic signed [44:0] bacc_ff;
   logic signed [25:0] res_ff [0:5];

   logic [39:0]  vnum_ff;
   logic [16:0]  vrem_ff;

   logic signed [27:0] left_ff, right_ff;
   logic signed [43:0] top_ff;

   logic         fin_blend_ff;
   logic         rsp_valid_ff;
   logic [103:0] rsp_data_ff;
   logic         rsp_user_ff;

   // Truncating shifts toward zero.
   function automatic logic signed [25:0] trunc8(input logic signed [25:0] v);
      logic signed [25:0] t;
      t = v + (v < 0 ? 26'sd255 : 26'sd0);
      return t >>> FRAC_BITS;
   endfunction

   function automatic logic signed [44:0] trunc16(input logic signed [44:0] v);
      logic signed [44:0] t;
      t = v + (v < 0 ? 45'sd65535 : 45'sd0);
      return t >>> WEIGHT_BITS;
   endfunction

   // Input item fields
   logic signed [16:0] in_x, in_y;
   assign in_x = req_tdata[16:0];
   assign in_y = req_tdata[33:17];

   // Centre and extent of the held box in fixed point
   logic signed [18:0] csum_x, csum_y;
   logic signed [25:0] cx, cy, tcx, tcy;
   logic [23:0]        ext;
   assign csum_x = 19'(bx_ff) * 19'sd2 + $signed({3'b0, bw_ff}) - 19'sd1;
   assign csum_y = 19'(by_ff) * 19'sd2 + $signed({3'b0, bh_ff}) - 19'sd1;
   assign cx  = 26'(csum_x) <<< (FRAC_BITS - 1);
   assign cy  = 26'(csum_y) <<< (FRAC_BITS - 1);
   assign tcx = trunc8(cx);
   assign tcy = trunc8(cy);
   assign ext = {bw_ff - 16'd1, 8'b0};

   // Limit checks
   logic box_ok;
   assign box_ok = (bx_ff >= -17'sd32768) && (18'(bx_ff) <= 18'sd32768)
                && (by_ff >= -17'sd32768) && (18'(by_ff) <= 18'sd32768)
                && (bw_ff >= 16'd2) && (17'(bw_ff) <= 17'(COORD_LIMIT))
                && (bh_ff >= 16'd1) && (17'(bh_ff) <= 17'(COORD_LIMIT))
                && (cap_ff <= 17'(REG_MAX)) && (share_ff <= 17'(REG_MAX))
                && (cols_ff != 16'd0) && (17'(cols_ff) <= 17'(COORD_LIMIT))
                && (rows_ff != 16'd0) && (17'(rows_ff) <= 17'(COORD_LIMIT));

   // Motion distance
   logic signed [26:0] dx;
   logic [26:0]        adx;
   logic [15:0]        side;
   assign dx   = 27'(cx) - 27'(scx_ff);
   assign adx  = dx < 0 ? 27'(-dx) : 27'(dx);
   assign side = cols_ff < rows_ff ? cols_ff : rows_ff;

   logic [43:0] wden, wrem2;
   assign wden  = {1'b0, dist_ff, 16'd0};
   assign wrem2 = {wrem_ff[42:0], 1'b0};

   // Weight selection
   logic [16:0] lim, inv_uw;
   assign lim    = cap_ff < 17'd65535 ? cap_ff : 17'd65535;
   assign inv_uw = 17'(REG_MAX) - uw_ff;

   // Shared blend multiplier
   logic signed [25:0] mul_a;
   logic signed [17:0] mul_b;
   logic               odd;
   logic [2:0]         pair;
   assign odd  = cnt_ff[0];
   assign pair = cnt_ff[3:1];
   assign mul_b = odd ? $signed({1'b0, 17'(17'(REG_MAX) - wt_ff)})
                      : $signed({1'b0, wt_ff});
   always_comb begin
      case (pair)
         3'd0: mul_a = odd ? tcx : trunc8(scx_ff);
         3'd1: mul_a = odd ? tcy : trunc8(scy_ff);
         3'd2: mul_a = odd ? $signed(26'(bw_ff - 16'd1))
                           : trunc8($signed({2'b0, sext_ff}));
         3'd3: mul_a = odd ? cx : scx_ff;
         3'd4: mul_a = odd ? cy : scy_ff;
         3'd5: mul_a = odd ? $signed({2'b0, ext}) : $signed({2'b0, sext_ff});
         default: mul_a = '0;
      endcase
   end

   logic [3:0]         bidx;
   logic signed [44:0] bsum;
   assign bidx = cnt_ff[3:0] - 4'd1;
   assign bsum = bacc_ff + 45'(prod_ff);

   // Vertical extent
   logic signed [25:0] e_val;
   logic [15:0]        e_u;
   logic [15:0]        wm1, hm1;
   logic [31:0]        vprod;
   logic [16:0]        vr;
   assign e_val = res_ff[2] < 0 ? 26'sd0 : res_ff[2];
   assign e_u   = e_val[15:0];
   assign wm1   = bw_ff - 16'd1;
   assign hm1   = bh_ff - 16'd1;
   assign vprod = hm1 * e_u;
   assign vr    = {vrem_ff[15:0], vnum_ff[39]};

   // Crop build
   logic signed [27:0] c_left, c_right;
   logic signed [43:0] c_td, c_top;
   assign c_left  = 28'(res_ff[0]) - 28'(e_val >>> 1);
   assign c_right = c_left + 28'(e_val);
   assign c_td    = (44'(res_ff[1]) <<< (FRAC_BITS + 1)) - $signed({4'b0, vnum_ff});
   assign c_top   = (c_td + (c_td < 0 ? 44'sd511 : 44'sd0)) >>> (FRAC_BITS + 1);

   logic signed [43:0] k_bot, k_botc, k_topc, k_fh, k_tall;
   logic signed [27:0] k_leftc, k_rightc, k_fw;
   assign k_bot    = (top_ff <<< FRAC_BITS) + $signed({4'b0, vnum_ff});
   assign k_fh     = $signed({20'b0, rows_ff, 8'b0});
   assign k_fw     = $signed({12'b0, cols_ff});
   assign k_botc   = k_bot > k_fh ? k_fh : k_bot;
   assign k_topc   = top_ff < 0 ? 44'sd0 : top_ff;
   assign k_leftc  = left_ff < 0 ? 28'sd0 : left_ff;
   assign k_rightc = right_ff > k_fw ? k_fw : right_ff;
   assign k_tall   = k_botc - (k_topc <<< FRAC_BITS);

   logic signed [43:0] k_tallt;
   assign k_tallt = (k_tall + (k_tall < 0 ? 44'sd255 : 44'sd0)) >>> FRAC_BITS;

   // Output register is loaded when ST_FIN hands over. The blended crop lands
   // in crop_ff on the first ST_FIN cycle, so the load is held off in that cycle.
   logic fin_go;
   assign fin_go = (state_ff == ST_FIN) && !fin_blend_ff && (!rsp_valid_ff || rsp_tready);

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_CHK;
         ST_CHK:   state_in = (!box_ok || first_ff) ? ST_FIN : ST_WPRE;
         ST_WPRE:  state_in = ST_WCMP;
         ST_WCMP:  state_in = ({3'b0, msprod_ff, 8'b0} >= wden) ? ST_WSEL : ST_WDIV;
         ST_WDIV:  if (cnt_ff == 6'd15) state_in = ST_WSEL;
         ST_WSEL:  state_in = ST_BLEND;
         ST_BLEND: if (cnt_ff == 6'd12) state_in = ST_VMUL;
         ST_VMUL:  state_in = ST_VDIV;
         ST_VDIV:  if (cnt_ff == 6'd39) state_in = ST_CROP;
         ST_CROP:  state_in = ST_FIN;
         ST_FIN:   if (fin_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= 17'd58982;
         share_ff     <= 17'd6554;
         cols_ff      <= 16'd1920;
         rows_ff      <= 16'd1080;
         first_ff     <= 1'b1;
         scx_ff       <= '0;
         scy_ff       <= '0;
         sext_ff      <= '0;
         count_ff     <= '0;
         for (int i = 0; i < 4; i++) crop_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
         fin_blend_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_HISTORY_CAP:  cap_ff   <= csr_wdata;
               CSR_MOTION_SHARE: share_ff <= csr_wdata;
               CSR_FRAME_COLS:   cols_ff  <= csr_wdata[15:0];
               CSR_FRAME_ROWS:   rows_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (fin_go) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  bx_ff <= in_x;
                  by_ff <= in_y;
                  bw_ff <= req_tdata[49:34];
                  bh_ff <= req_tdata[65:50];
               end
            end
            ST_CHK: begin
               acc_ff <= box_ok;
               if (box_ok && first_ff) begin
                  first_ff   <= 1'b0;
                  scx_ff     <= cx;
                  scy_ff     <= cy;
                  sext_ff    <= ext;
                  crop_ff[0] <= 18'(bx_ff);
                  crop_ff[1] <= 18'(by_ff);
                  crop_ff[2] <= {2'b0, bw_ff};
                  crop_ff[3] <= {2'b0, bh_ff};
                  count_ff   <= count_ff + 32'd1;
               end
            end
            ST_WPRE: begin
               msprod_ff <= share_ff * side;
               dist_ff   <= adx + 27'd256;
            end
            ST_WCMP: begin
               wrem_ff <= {3'b0, msprod_ff, 8'b0};
               uw_ff   <= 17'(REG_MAX);
               cnt_ff  <= '0;
            end
            ST_WDIV: begin
               // the preset top bit shifts out on the first step
               if (wrem2 >= wden) begin
                  wrem_ff <= wrem2 - wden;
                  uw_ff   <= {uw_ff[15:0], 1'b1};
               end else begin
                  wrem_ff <= wrem2;
                  uw_ff   <= {uw_ff[15:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
            end
            ST_WSEL: begin
               wt_ff  <= lim > inv_uw ? lim : inv_uw;
               cnt_ff <= '0;
            end
            ST_BLEND: begin
               if (cnt_ff < 6'd12) prod_ff <= mul_a * mul_b;
               if (cnt_ff != 6'd0) begin
                  if (!bidx[0]) bacc_ff <= 45'(prod_ff);
                  else res_ff[bidx[3:1]] <= 26'(trunc16(bsum));
               end
               cnt_ff <= (cnt_ff == 6'd12) ? 6'd0 : cnt_ff + 6'd1;
            end
            ST_VMUL: begin
               vnum_ff <= {vprod, 8'b0};
               vrem_ff <= '0;
               cnt_ff  <= '0;
            end
            ST_VDIV: begin
               if (vr >= {1'b0, wm1}) begin
                  vrem_ff <= vr - {1'b0, wm1};
                  vnum_ff <= {vnum_ff[38:0], 1'b1};
               end else begin
                  vrem_ff <= vr;
                  vnum_ff <= {vnum_ff[38:0], 1'b0};
               end
               cnt_ff <= (cnt_ff == 6'd39) ? 6'd0 : cnt_ff + 6'd1;
            end
            ST_CROP: begin
               left_ff  <= c_left;
               right_ff <= c_right;
               top_ff   <= c_top;
            end
            default: ;
         endcase

         // Clamp and state update for a blended box, in the cycle after ST_CROP.
         if (state_ff == ST_CROP) begin
            fin_blend_ff <= 1'b1;
         end else begin
            fin_blend_ff <= 1'b0;
         end
         if (fin_blend_ff) begin
            crop_ff[0] <= 18'(k_leftc);
            crop_ff[1] <= 18'(k_topc);
            crop_ff[2] <= 18'(k_rightc - k_leftc);
            crop_ff[3] <= 18'(k_tallt);
            scx_ff     <= res_ff[3];
            scy_ff     <= res_ff[4];
            sext_ff    <= res_ff[5][23:0];
            count_ff   <= count_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_data_ff <= {count_ff, crop_ff[3], crop_ff[2], crop_ff[1], crop_ff[0]};
         rsp_user_ff <= acc_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### src/tcs_checker.sv
// Port-level checker for the temporal crop smoother, bound to the top level.
module tcs_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic         rsp_tuser
);

   // A held result does not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // One box at a time: taking a box closes the input.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open right after a box was taken");

   // Reset empties the output register.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A new result only appears while a box is in work.
   a_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without a box");

endmodule

bind temporal_crop_smoother tcs_checker u_tcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
